[rtl/stsub_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere triangle subdivider package
// Shared widths, types and arithmetic step functions.
// ----------------------------------------------------------------------------
package stsub_pkg;

	localparam int COORD_W       = 32;
	localparam int RADIUS_W      = 31;
	localparam int SLOT_W        = 16;
	localparam int SLOT_COUNT    = 65536;
	localparam int SLOT_CMP_W    = 21;
	localparam int RADIUS_RESET  = 65536;
	localparam int SQ_W          = 2 * COORD_W;
	localparam int PROD_W        = COORD_W + RADIUS_W;
	localparam int QUO_W         = RADIUS_W;
	localparam int SQRT_STAGES   = COORD_W / 2;
	localparam int DIV_STAGES    = (QUO_W + 1) / 2;

	typedef logic [2:0][COORD_W-1:0] vec_t;

	typedef enum logic [1:0] {
		MID_AB,
		MID_AC,
		MID_BC
	} mid_sel_t;

	typedef enum logic [1:0] {
		RES_CENTER,
		RES_B_CORNER,
		RES_C_CORNER,
		RES_A_CORNER
	} res_sel_t;

	typedef struct packed {
		mid_sel_t            sel;
		vec_t                vert;
		logic [SLOT_W-1:0]   slot;
	} side_t;

	typedef struct packed {
		side_t side;
		vec_t  u;
		vec_t  v;
	} mid_job_t;

	typedef struct packed {
		side_t side;
		vec_t  mid;
		logic  deg;
	} mid_res_t;

	typedef struct packed {
		logic [COORD_W+1:0] rem;
		logic [COORD_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		side_t                   side;
		logic [2:0]              neg;
		logic                    deg;
		logic [SQ_W-1:0]         n;
		sqrt_t                   rt;
		logic [2:0][PROD_W-1:0]  prod;
	} root_job_t;

	typedef struct packed {
		side_t                   side;
		logic [2:0]              neg;
		logic                    deg;
		logic [COORD_W-1:0]      len;
		logic [2:0][PROD_W-1:0]  d;
		logic [2:0]              sat;
		logic [2:0][QUO_W-1:0]   q;
	} div_job_t;

	typedef struct packed {
		logic [PROD_W-1:0] d;
		logic              hit;
	} div_t;

	// One restoring square root step: brings down one bit pair of the radicand.
	function automatic sqrt_t sqrt_step(sqrt_t cur, logic [1:0] pair);
		logic [COORD_W+3:0] r2;
		logic [COORD_W+3:0] trial;
		sqrt_t nxt;
		r2    = {cur.rem, pair};
		trial = {2'b00, cur.root, 2'b01};
		if (r2 >= trial) begin
			nxt.rem  = (COORD_W+2)'(r2 - trial);
			nxt.root = {cur.root[COORD_W-2:0], 1'b1};
		end else begin
			nxt.rem  = r2[COORD_W+1:0];
			nxt.root = {cur.root[COORD_W-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// One long division step against the divisor shifted to quotient bit sh.
	function automatic div_t div_step(logic [PROD_W-1:0] d, logic [COORD_W-1:0] len,
			int unsigned sh);
		logic [PROD_W-1:0] ls;
		div_t r;
		ls    = {{(PROD_W-COORD_W){1'b0}}, len} << sh;
		r.hit = (d >= ls);
		r.d   = r.hit ? (d - ls) : d;
		return r;
	endfunction

endpackage

[rtl/stsub_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere triangle subdivider channels
// Triangle input, result triangle output and radius write channel.
// ----------------------------------------------------------------------------
interface stsub_in_if;
	logic                                valid;
	logic                                ready;
	logic [stsub_pkg::SLOT_W-1:0]        slot_index;
	logic signed [stsub_pkg::COORD_W-1:0] a_x, a_y, a_z;
	logic signed [stsub_pkg::COORD_W-1:0] b_x, b_y, b_z;
	logic signed [stsub_pkg::COORD_W-1:0] c_x, c_y, c_z;

	modport source (output valid, slot_index, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, input ready);
	modport sink (input valid, slot_index, a_x, a_y, a_z, b_x, b_y, b_z,
		c_x, c_y, c_z, output ready);
endinterface

interface stsub_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [stsub_pkg::COORD_W-1:0] p_x, p_y, p_z;
	logic signed [stsub_pkg::COORD_W-1:0] q_x, q_y, q_z;
	logic signed [stsub_pkg::COORD_W-1:0] r_x, r_y, r_z;
	logic [stsub_pkg::SLOT_W-1:0]        target_slot;
	logic                                is_last;
	logic                                degenerate;

	modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
		target_slot, is_last, degenerate, input ready);
	modport sink (input valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
		target_slot, is_last, degenerate, output ready);
endinterface

interface stsub_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [stsub_pkg::RADIUS_W-1:0]     sphere_radius;

	modport source (output valid, sphere_radius, input ready);
	modport sink (input valid, sphere_radius, output ready);
endinterface

[rtl/stsub_mid_proj.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint projection pipeline
// Takes one edge per cycle while en is high and scales its midpoint out to the sphere radius.
// ----------------------------------------------------------------------------
module stsub_mid_proj (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  stsub_pkg::mid_job_t               in_job,
	input  logic [stsub_pkg::RADIUS_W-1:0]    radius,
	output logic                              out_valid,
	output stsub_pkg::mid_res_t               out_res
);

	localparam int CW = stsub_pkg::COORD_W;
	localparam int PW = stsub_pkg::PROD_W;
	localparam int SW = stsub_pkg::SQ_W;

	// Stage 1: edge sum, halved when any component leaves the coordinate range.
	logic signed [CW:0] sum [3];
	stsub_pkg::vec_t    t_c;
	logic               fits;

	logic               v_s1;
	stsub_pkg::vec_t    t_s1;
	stsub_pkg::side_t   side_s1;

	always_comb begin
		fits = 1'b1;
		for (int c = 0; c < 3; c++) begin
			sum[c] = (CW+1)'($signed(in_job.u[c])) + (CW+1)'($signed(in_job.v[c]));
			if (sum[c][CW] != sum[c][CW-1])
				fits = 1'b0;
		end
		for (int c = 0; c < 3; c++)
			t_c[c] = fits ? sum[c][CW-1:0] : sum[c][CW:1];
	end

	// Stage 2: magnitudes, squares and radius products.
	logic [CW-1:0]        mag [3];
	logic                 v_s2;
	logic [2:0]           neg_s2;
	logic [2:0][PW-1:0]   sq_s2;
	logic [2:0][PW-1:0]   prod_s2;
	stsub_pkg::side_t     side_s2;

	always_comb begin
		for (int c = 0; c < 3; c++)
			mag[c] = t_s1[c][CW-1] ? (CW'(0) - t_s1[c]) : t_s1[c];
	end

	// Stage 3: sum of squares.
	logic [SW-1:0]          n_c;
	logic                   v_s3;
	stsub_pkg::root_job_t   rj_s3;

	assign n_c = SW'(sq_s2[0]) + SW'(sq_s2[1]) + SW'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_c;
			side_s1 <= in_job.side;
			side_s2 <= side_s1;
			for (int c = 0; c < 3; c++) begin
				neg_s2[c]  <= t_s1[c][CW-1];
				sq_s2[c]   <= {{(PW-CW){1'b0}}, mag[c]} * {{(PW-CW){1'b0}}, mag[c]};
				prod_s2[c] <= {{(PW-CW){1'b0}}, mag[c]} *
					{{(PW-stsub_pkg::RADIUS_W){1'b0}}, radius};
			end
			rj_s3.side <= side_s2;
			rj_s3.neg  <= neg_s2;
			rj_s3.deg  <= (n_c == '0);
			rj_s3.n    <= n_c;
			rj_s3.rt   <= '0;
			rj_s3.prod <= prod_s2;
		end
	end

	// Square root: two result bits per stage.
	logic                  rv_s [stsub_pkg::SQRT_STAGES];
	stsub_pkg::root_job_t  rj_s [stsub_pkg::SQRT_STAGES];

	for (genvar j = 0; j < stsub_pkg::SQRT_STAGES; j++) begin : g_sqrt
		localparam int HI = SW - 1 - 4 * j;
		stsub_pkg::root_job_t prev;
		stsub_pkg::root_job_t nxt;
		logic                 prev_v;

		if (j == 0) begin : g_first
			assign prev   = rj_s3;
			assign prev_v = v_s3;
		end else begin : g_next
			assign prev   = rj_s[j-1];
			assign prev_v = rv_s[j-1];
		end

		always_comb begin
			nxt    = prev;
			nxt.rt = stsub_pkg::sqrt_step(stsub_pkg::sqrt_step(prev.rt, prev.n[HI -: 2]),
				prev.n[HI-2 -: 2]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rv_s[j] <= 1'b0;
			else if (en)
				rv_s[j] <= prev_v;
		end

		always_ff @(posedge clk) begin
			if (en)
				rj_s[j] <= nxt;
		end
	end

	// Division setup: rounding offset and saturation check.
	stsub_pkg::root_job_t  rj_last;
	logic [PW-1:0]         d_c [3];
	logic                  dv_s0;
	stsub_pkg::div_job_t   dj_s0;

	assign rj_last = rj_s[stsub_pkg::SQRT_STAGES-1];

	always_comb begin
		for (int c = 0; c < 3; c++)
			d_c[c] = rj_last.prod[c] + PW'(rj_last.rt.root >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_s0 <= 1'b0;
		else if (en)
			dv_s0 <= rv_s[stsub_pkg::SQRT_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dj_s0.side <= rj_last.side;
			dj_s0.neg  <= rj_last.neg;
			dj_s0.deg  <= rj_last.deg;
			dj_s0.len  <= rj_last.rt.root;
			dj_s0.q    <= '0;
			for (int c = 0; c < 3; c++) begin
				dj_s0.d[c]   <= d_c[c];
				dj_s0.sat[c] <= (d_c[c] >= {rj_last.rt.root, {stsub_pkg::QUO_W{1'b0}}});
			end
		end
	end

	// Long division: two quotient bits per stage (one in the last stage), three components side by side.
	logic                 dv_s [stsub_pkg::DIV_STAGES];
	stsub_pkg::div_job_t  dj_s [stsub_pkg::DIV_STAGES];

	for (genvar k = 0; k < stsub_pkg::DIV_STAGES; k++) begin : g_div
		localparam int  B0  = stsub_pkg::QUO_W - 1 - 2 * k;
		localparam bit  TWO = (B0 > 0);
		localparam int  B1  = TWO ? B0 - 1 : 0;
		stsub_pkg::div_job_t prev;
		stsub_pkg::div_job_t nxt;
		logic                prev_v;
		stsub_pkg::div_t     st0 [3];
		stsub_pkg::div_t     st1 [3];

		if (k == 0) begin : g_first
			assign prev   = dj_s0;
			assign prev_v = dv_s0;
		end else begin : g_next
			assign prev   = dj_s[k-1];
			assign prev_v = dv_s[k-1];
		end

		always_comb begin
			nxt = prev;
			for (int c = 0; c < 3; c++) begin
				st0[c]        = stsub_pkg::div_step(prev.d[c], prev.len, B0);
				nxt.q[c][B0]  = st0[c].hit;
				if (TWO) begin
					st1[c]       = stsub_pkg::div_step(st0[c].d, prev.len, B1);
					nxt.q[c][B1] = st1[c].hit;
				end else begin
					st1[c] = st0[c];
				end
				nxt.d[c] = st1[c].d;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s[k] <= 1'b0;
			else if (en)
				dv_s[k] <= prev_v;
		end

		always_ff @(posedge clk) begin
			if (en)
				dj_s[k] <= nxt;
		end
	end

	// Final stage: saturate, restore the sign, zero a degenerate midpoint.
	stsub_pkg::div_job_t  dj_last;
	logic [CW-1:0]        qv [3];
	stsub_pkg::vec_t      mid_c;
	logic                 fv_s;
	stsub_pkg::mid_res_t  fr_s;

	assign dj_last = dj_s[stsub_pkg::DIV_STAGES-1];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qv[c] = {1'b0, dj_last.sat[c] ? {stsub_pkg::QUO_W{1'b1}} : dj_last.q[c]};
			if (dj_last.deg)
				mid_c[c] = '0;
			else
				mid_c[c] = dj_last.neg[c] ? (CW'(0) - qv[c]) : qv[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fv_s <= 1'b0;
		else if (en)
			fv_s <= dv_s[stsub_pkg::DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s.side <= dj_last.side;
			fr_s.mid  <= mid_c;
			fr_s.deg  <= dj_last.deg;
		end
	end

	assign out_valid = fv_s;
	assign out_res   = fr_s;

endmodule

[rtl/sphere_triangle_subdivider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere triangle subdivider
// Splits one triangle into four, projecting edge midpoints onto a sphere.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Transfer moves
//  ---------+-----+-----------------------------------------------------------
//  tri_in   | in  | one triangle: slot_index, vertices a, b, c
//  tri_out  | out | one result triangle p, q, r with target_slot, flags
//  cfg      | in  | sphere_radius write, always ready
//
//  Each triangle issues its edges AB, AC and BC into a shared projection
//  pipeline, one edge per cycle while the pipeline advances, and yields
//  four output transfers; the output channel sets the sustained rate.
//  Reset sets the radius to 1.0 and empties all stages.
//  A stall on tri_out freezes the pipeline only when a finished triangle
//  cannot move into the output bank; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module sphere_triangle_subdivider (
	input  logic        clk,
	input  logic        arst_n,
	stsub_in_if.sink    tri_in,
	stsub_out_if.source tri_out,
	stsub_cfg_if.sink   cfg
);

	// Radius register.
	logic [stsub_pkg::RADIUS_W-1:0] radius_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radius_q <= stsub_pkg::RADIUS_W'(stsub_pkg::RADIUS_RESET);
		else if (cfg.valid)
			radius_q <= cfg.sphere_radius;
	end

	// Edge issue.
	logic                          adv;
	logic                          in_fire;
	logic                          issue;
	logic                          iss_busy_q;
	stsub_pkg::mid_sel_t           iss_sel_q;
	stsub_pkg::vec_t               tri_a_q, tri_b_q, tri_c_q;
	logic [stsub_pkg::SLOT_W-1:0]  slot_q;
	logic [stsub_pkg::SLOT_W-1:0]  slot_sat;
	stsub_pkg::mid_job_t           job;

	assign tri_in.ready = !iss_busy_q || (iss_sel_q == stsub_pkg::MID_BC && adv);
	assign in_fire      = tri_in.valid && tri_in.ready;
	assign issue        = iss_busy_q && adv;

	assign slot_sat = (stsub_pkg::SLOT_CMP_W'(tri_in.slot_index) >=
		stsub_pkg::SLOT_CMP_W'(stsub_pkg::SLOT_COUNT)) ?
		stsub_pkg::SLOT_W'(stsub_pkg::SLOT_COUNT - 1) : tri_in.slot_index;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_busy_q <= 1'b0;
			iss_sel_q  <= stsub_pkg::MID_AB;
		end else if (in_fire) begin
			iss_busy_q <= 1'b1;
			iss_sel_q  <= stsub_pkg::MID_AB;
		end else if (issue) begin
			unique case (iss_sel_q)
				stsub_pkg::MID_AB: iss_sel_q  <= stsub_pkg::MID_AC;
				stsub_pkg::MID_AC: iss_sel_q  <= stsub_pkg::MID_BC;
				default:           iss_busy_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			tri_a_q <= {tri_in.a_z, tri_in.a_y, tri_in.a_x};
			tri_b_q <= {tri_in.b_z, tri_in.b_y, tri_in.b_x};
			tri_c_q <= {tri_in.c_z, tri_in.c_y, tri_in.c_x};
			slot_q  <= slot_sat;
		end
	end

	// Each edge carries the one original vertex the collector still needs.
	always_comb begin
		job.side.sel  = iss_sel_q;
		job.side.slot = slot_q;
		unique case (iss_sel_q)
			stsub_pkg::MID_AC: begin
				job.u = tri_a_q;
				job.v = tri_c_q;
				job.side.vert = tri_c_q;
			end
			stsub_pkg::MID_BC: begin
				job.u = tri_b_q;
				job.v = tri_c_q;
				job.side.vert = tri_b_q;
			end
			default: begin
				job.u = tri_a_q;
				job.v = tri_b_q;
				job.side.vert = tri_a_q;
			end
		endcase
	end

	// Projection pipeline.
	logic                 pv;
	stsub_pkg::mid_res_t  pres;

	stsub_mid_proj u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (issue),
		.in_job   (job),
		.radius   (radius_q),
		.out_valid(pv),
		.out_res  (pres)
	);

	// Collector and output bank.
	logic                 out_fire;
	logic                 load;
	stsub_pkg::vec_t      col_mab_q, col_mac_q, col_va_q, col_vc_q;
	logic                 col_deg_q;
	logic                 em_valid_q;
	stsub_pkg::res_sel_t  em_cnt_q;
	stsub_pkg::vec_t      em_mab_q, em_mac_q, em_mbc_q, em_va_q, em_vb_q, em_vc_q;
	logic [stsub_pkg::SLOT_W-1:0] em_slot_q;
	logic                 em_deg_q;

	assign out_fire = tri_out.valid && tri_out.ready;
	assign adv = !(pv && pres.side.sel == stsub_pkg::MID_BC && em_valid_q &&
		!(out_fire && em_cnt_q == stsub_pkg::RES_A_CORNER));
	assign load = pv && adv && pres.side.sel == stsub_pkg::MID_BC;

	always_ff @(posedge clk) begin
		if (pv && adv) begin
			unique case (pres.side.sel)
				stsub_pkg::MID_AB: begin
					col_mab_q <= pres.mid;
					col_va_q  <= pres.side.vert;
					col_deg_q <= pres.deg;
				end
				stsub_pkg::MID_AC: begin
					col_mac_q <= pres.mid;
					col_vc_q  <= pres.side.vert;
					col_deg_q <= col_deg_q | pres.deg;
				end
				default: begin
					em_mab_q  <= col_mab_q;
					em_mac_q  <= col_mac_q;
					em_mbc_q  <= pres.mid;
					em_va_q   <= col_va_q;
					em_vb_q   <= pres.side.vert;
					em_vc_q   <= col_vc_q;
					em_slot_q <= pres.side.slot;
					em_deg_q  <= col_deg_q | pres.deg;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_valid_q <= 1'b0;
			em_cnt_q   <= stsub_pkg::RES_CENTER;
		end else if (load) begin
			em_valid_q <= 1'b1;
			em_cnt_q   <= stsub_pkg::RES_CENTER;
		end else if (out_fire) begin
			if (em_cnt_q == stsub_pkg::RES_A_CORNER)
				em_valid_q <= 1'b0;
			em_cnt_q <= stsub_pkg::res_sel_t'(em_cnt_q + 2'd1);
		end
	end

	stsub_pkg::vec_t pv_o, qv_o, rv_o;

	always_comb begin
		case (em_cnt_q)
			stsub_pkg::RES_CENTER: begin
				pv_o = em_mab_q;
				qv_o = em_mbc_q;
				rv_o = em_mac_q;
			end
			stsub_pkg::RES_B_CORNER: begin
				pv_o = em_mab_q;
				qv_o = em_vb_q;
				rv_o = em_mbc_q;
			end
			stsub_pkg::RES_C_CORNER: begin
				pv_o = em_mac_q;
				qv_o = em_mbc_q;
				rv_o = em_vc_q;
			end
			default: begin
				pv_o = em_va_q;
				qv_o = em_mab_q;
				rv_o = em_mac_q;
			end
		endcase
	end

	assign tri_out.valid       = em_valid_q;
	assign tri_out.p_x         = $signed(pv_o[0]);
	assign tri_out.p_y         = $signed(pv_o[1]);
	assign tri_out.p_z         = $signed(pv_o[2]);
	assign tri_out.q_x         = $signed(qv_o[0]);
	assign tri_out.q_y         = $signed(qv_o[1]);
	assign tri_out.q_z         = $signed(qv_o[2]);
	assign tri_out.r_x         = $signed(rv_o[0]);
	assign tri_out.r_y         = $signed(rv_o[1]);
	assign tri_out.r_z         = $signed(rv_o[2]);
	assign tri_out.target_slot = em_slot_q;
	assign tri_out.is_last     = (em_cnt_q == stsub_pkg::RES_A_CORNER);
	assign tri_out.degenerate  = em_deg_q;

endmodule

[bench/tb_stsub_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subdivider result checker
// Watches the triangle, result and radius channels, computes the four result
// triangles of every accepted triangle and compares each result transfer
// field by field against the oldest one still outstanding.
// ----------------------------------------------------------------------------
module tb_stsub_checker (
	input  logic        clk,
	input  logic        arst_n,
	stsub_in_if.sink    tri_in,
	stsub_out_if.sink   tri_out,
	stsub_cfg_if.sink   cfg,
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output int          degen_seen
);

	typedef struct packed {
		stsub_pkg::vec_t              p;
		stsub_pkg::vec_t              q;
		stsub_pkg::vec_t              r;
		logic [stsub_pkg::SLOT_W-1:0] slot;
		logic                         last;
		logic                         deg;
	} tri_res_t;

	tri_res_t                       result_queue[$];
	logic [stsub_pkg::RADIUS_W-1:0] radius;

	function automatic logic [63:0] int_sqrt(logic [63:0] n);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Projects the midpoint of u and v onto the sphere; returns degenerate.
	function automatic logic project(stsub_pkg::vec_t u, stsub_pkg::vec_t v,
			output stsub_pkg::vec_t m);
		logic signed [33:0] s[3];
		logic signed [33:0] t[3];
		logic [63:0] mag[3];
		logic [63:0] n;
		logic [63:0] len;
		logic [127:0] q;
		logic fits;
		fits = 1;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			s[i] = 34'(signed'(u[i])) + 34'(signed'(v[i]));
			if (s[i] < -34'sd2147483648 || s[i] > 34'sd2147483647) fits = 0;
		end
		for (int i = 0; i < 3; i++) begin
			t[i] = fits ? s[i] : (s[i] >>> 1);
			mag[i] = t[i] < 0 ? 64'(-t[i]) : 64'(t[i]);
			n = n + mag[i] * mag[i];
		end
		if (n == 0) begin
			m = '0;
			return 1;
		end
		len = int_sqrt(n);
		for (int i = 0; i < 3; i++) begin
			q = (128'(mag[i]) * 128'(radius) + 128'(len >> 1)) / 128'(len);
			if (q > 128'h7FFFFFFF) q = 128'h7FFFFFFF;
			m[i] = t[i] < 0 ? 32'(-q) : 32'(q);
		end
		return 0;
	endfunction

	task automatic predict_split();
		stsub_pkg::vec_t a, b, c, mab, mac, mbc;
		logic deg;
		logic [stsub_pkg::SLOT_W-1:0] slot;
		a = {tri_in.a_z, tri_in.a_y, tri_in.a_x};
		b = {tri_in.b_z, tri_in.b_y, tri_in.b_x};
		c = {tri_in.c_z, tri_in.c_y, tri_in.c_x};
		slot = tri_in.slot_index;
		deg = project(a, b, mab);
		deg = project(a, c, mac) | deg;
		deg = project(b, c, mbc) | deg;
		result_queue.push_back('{mab, mbc, mac, slot, 1'b0, deg});
		result_queue.push_back('{mab, b, mbc, slot, 1'b0, deg});
		result_queue.push_back('{mac, mbc, c, slot, 1'b0, deg});
		result_queue.push_back('{a, mab, mac, slot, 1'b1, deg});
	endtask

	task automatic compare_result();
		tri_res_t want, got;
		got.p = {tri_out.p_z, tri_out.p_y, tri_out.p_x};
		got.q = {tri_out.q_z, tri_out.q_y, tri_out.q_x};
		got.r = {tri_out.r_z, tri_out.r_y, tri_out.r_x};
		got.slot = tri_out.target_slot;
		got.last = tri_out.is_last;
		got.deg = tri_out.degenerate;
		results_seen++;
		if (got.deg && got.last) degen_seen++;
		if (result_queue.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) $display("unexpected result transfer %p", got);
			return;
		end
		want = result_queue.pop_front();
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("mismatch at %0t\n  expected %p\n  actual   %p", $realtime, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius = stsub_pkg::RADIUS_W'(stsub_pkg::RADIUS_RESET);
			fail_count = 0;
			results_seen = 0;
			degen_seen = 0;
			pending = result_queue.size();
		end else begin
			if (tri_out.valid && tri_out.ready) compare_result();
			if (tri_in.valid && tri_in.ready) predict_split();
			if (cfg.valid && cfg.ready) radius = cfg.sphere_radius;
			pending = result_queue.size();
		end
	end
endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Subdivider testbench top
// Drives directed and random triangles under several radii with random
// idling on both channels and one long output stall; reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending, results_seen, degen_seen;
	int   idle_cycles = 0;
	bit   quiet = 0;
	bit   hold_off = 0;
	int   sent = 0;

	stsub_in_if  tri_in();
	stsub_out_if tri_out();
	stsub_cfg_if cfg();

	sphere_triangle_subdivider DUT (.clk(clk), .arst_n(arst_n), .tri_in(tri_in),
		.tri_out(tri_out), .cfg(cfg));

	tb_stsub_checker checker_i (.clk(clk), .arst_n(arst_n), .tri_in(tri_in),
		.tri_out(tri_out), .cfg(cfg), .fail_count(fail_count), .pending(pending),
		.results_seen(results_seen), .degen_seen(degen_seen));

	always #10 clk = ~clk;

	initial begin
		tri_in.valid = 0;
		tri_in.slot_index = 0;
		{tri_in.a_x, tri_in.a_y, tri_in.a_z} = '0;
		{tri_in.b_x, tri_in.b_y, tri_in.b_z} = '0;
		{tri_in.c_x, tri_in.c_y, tri_in.c_z} = '0;
		tri_out.ready = 0;
		cfg.valid = 0;
		cfg.sphere_radius = 0;
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tri_in.valid && tri_in.ready) || (tri_out.valid && tri_out.ready)
					|| (cfg.valid && cfg.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 5000) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Result side: random stall bursts, or a long hold-off when asked.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				tri_out.ready <= 0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				tri_out.ready <= 0;
				n = $urandom_range(1, 18);
				repeat (n) @(posedge clk);
			end else begin
				tri_out.ready <= 1;
				n = $urandom_range(1, 20);
				repeat (n) @(posedge clk);
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 200000))
				: -32'($urandom_range(0, 200000));
			3: return 32'($urandom_range(0, 8)) - 32'd4;
			default: return $urandom;
		endcase
	endfunction

	// Valid stays high after a transfer so that the next triangle follows
	// with no gap; idling or draining lowers it.
	task automatic send_tri(logic [15:0] slot, stsub_pkg::vec_t a, stsub_pkg::vec_t b,
			stsub_pkg::vec_t c);
		int n;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			tri_in.valid <= 0;
			n = $urandom_range(1, 18);
			repeat (n) @(posedge clk);
		end
		tri_in.valid <= 1;
		tri_in.slot_index <= slot;
		{tri_in.a_z, tri_in.a_y, tri_in.a_x} <= a;
		{tri_in.b_z, tri_in.b_y, tri_in.b_x} <= b;
		{tri_in.c_z, tri_in.c_y, tri_in.c_x} <= c;
		do @(posedge clk); while (!tri_in.ready);
		sent++;
	endtask

	task automatic send_random();
		stsub_pkg::vec_t a, b, c;
		for (int i = 0; i < 3; i++) begin
			a[i] = rand_coord();
			b[i] = rand_coord();
			c[i] = rand_coord();
		end
		// Opposite vertices now and then put a midpoint at the origin.
		if ($urandom_range(0, 9) == 0) b = {-a[2], -a[1], -a[0]};
		send_tri(16'($urandom), a, b, c);
	endtask

	task automatic drain_and_set(logic [30:0] r);
		tri_in.valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg.valid <= 1;
		cfg.sphere_radius <= r;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 0;
	endtask

	initial begin
		stsub_pkg::vec_t one_x, one_y, zero, mx, mn;
		int guard;
		one_x = {32'd0, 32'd0, 32'h10000};
		one_y = {32'd0, 32'h10000, 32'd0};
		zero = '0;
		mx = {3{32'h7FFFFFFF}};
		mn = {3{32'h80000000}};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: unit triangle, extremes, origin midpoints, slot extremes.
		send_tri(16'd0, one_x, one_y, {32'h10000, 32'd0, 32'd0});
		send_tri(16'hFFFF, mx, mx, mx);
		send_tri(16'h8000, mn, mn, mn);
		send_tri(16'd1, mx, mn, zero);
		send_tri(16'd2, zero, zero, zero);
		send_tri(16'd3, one_x, {32'd0, 32'd0, -32'h10000}, one_y);
		send_tri(16'h7FFF, {32'h7FFFFFFF, 32'h80000000, 32'd1},
			{32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF}, mx);
		send_tri(16'd5, {32'd1, 32'd0, 32'd0}, {32'd0, 32'd1, 32'd0}, {32'hFFFFFFFF, 32'd0, 32'd0});
		drain_and_set(31'h7FFFFFFF);
		send_tri(16'd6, one_x, one_y, mx);
		send_tri(16'd7, {32'd0, 32'd0, 32'd1}, {32'd0, 32'd1, 32'd0}, mn);
		drain_and_set(31'd0);
		send_tri(16'd8, one_x, one_y, mn);
		send_tri(16'd9, mx, mn, one_x);

		// Random phases under several radii.
		for (int ph = 0; ph < 5; ph++) begin
			drain_and_set(ph == 0 ? 31'h40000000 : ph == 4 ? 31'd65536 : 31'($urandom));
			if (ph == 2) hold_off = 1;
			if (ph == 4) quiet = 1;
			for (int k = 0; k < 38; k++) send_random();
		end
		tri_in.valid <= 0;

		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
		$display("%0d triangles sent, %0d results checked, %0d with a midpoint at the origin",
			sent, results_seen, degen_seen / 1);
		$display("radii covered zero, unity, half range and full range");
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

[sphere_triangle_subdivider.f]
rtl/stsub_pkg.sv
rtl/stsub_ifs.sv
rtl/stsub_mid_proj.sv
rtl/sphere_triangle_subdivider.sv
bench/tb_stsub_checker.sv
bench/tb_top.sv
